// ===== design/xrgc_pkg.sv =====
package xrgc_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_IN_WIDTH      = 16;
  localparam int DEF_OUT_WIDTH     = 18;
  localparam int DEF_LUT_ADDR_BITS = 10;

  // Channel count and matrix selection
  localparam int N_CHAN   = 3;
  localparam int SEL_W    = 3;
  localparam int N_MATRIX = 8;

  // Matrix arithmetic: signed Q.14 coefficients
  localparam int COEF_W    = 18;
  localparam int FRAC_BITS = 14;

  // Companding constants
  localparam int LIN_THRESHOLD = 51;      // 0.0031308 in Q.14
  localparam int LIMIT_BITS    = 19;      // power table covers [0, 32.0)
  localparam int WORD_W        = 19;      // power table word, Q.16
  localparam int MAG_W         = 29;      // linear branch magnitude, capped at 2^28
  localparam int LIN_GAIN      = 846725;  // 12.92 in Q.16
  localparam int LIN_GAIN_W    = 20;
  localparam int LIN_SHIFT     = 16;
  localparam int GAMMA_GAIN    = 69140;   // 1.055 in Q.16
  localparam int GAMMA_GAIN_W  = 17;
  localparam int GAMMA_SHIFT   = 18;
  localparam int GAMMA_OFFSET  = 901;     // 0.055 in Q.14
  localparam int RES_W         = 35;      // signed result before saturation

  // Pipeline depth
  localparam int MATRIX_STAGES  = 2;
  localparam int COMPAND_STAGES = 6;
  localparam int LATENCY        = MATRIX_STAGES + COMPAND_STAGES;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Row-major 3x3 matrices; selector 7 repeats the precise D65 default
  localparam coef_t COEF [N_MATRIX][9] = '{
    '{18'sd53092, -18'sd25184, -18'sd8168, -18'sd15880, 18'sd30737, 18'sd681,
      18'sd912, -18'sd3343, 18'sd17322},
    '{18'sd35799, -18'sd18006, -18'sd1868, -18'sd17990, 18'sd36536, -18'sd1278,
      18'sd1638, -18'sd7815, 18'sd66699},
    '{18'sd54739, -18'sd26853, -18'sd9880, -18'sd14385, 18'sd29032, 18'sd705,
      18'sd688, -18'sd2343, 18'sd15122},
    '{18'sd51806, -18'sd27066, -18'sd8077, -18'sd16581, 18'sd32080, 18'sd590,
      18'sd1245, -18'sd3834, 18'sd23020},
    '{18'sd53092, -18'sd25185, -18'sd8168, -18'sd15880, 18'sd30736, 18'sd681,
      18'sd912, -18'sd3343, 18'sd17323},
    '{18'sd56721, -18'sd29753, -18'sd8831, -18'sd14828, 18'sd30441, 18'sd393,
      18'sd197, -18'sd1442, 18'sd16450},
    '{18'sd55099, -18'sd27673, -18'sd8159, -18'sd15647, 18'sd30589, 18'sd606,
      18'sd508, -18'sd2720, 18'sd17957},
    '{18'sd53092, -18'sd25184, -18'sd8168, -18'sd15880, 18'sd30737, 18'sd681,
      18'sd912, -18'sd3343, 18'sd17322}
  };

  // Per-channel status handed from a compander to the top level
  typedef struct packed {
    logic valid;
    logic clip;
  } ch_stat_t;

  // Width of the rounded linear value for a given input width
  function automatic int lin_width(input int in_w);
    int w;
    w = COEF_W + in_w + 3 - FRAC_BITS;
    return (w > LIMIT_BITS + 1) ? w : LIMIT_BITS + 1;
  endfunction

  // Power table word (n / 2^14)^(5/12) in Q.16; evaluated at elaboration only
  function automatic logic [WORD_W-1:0] pow_word(input logic [LIMIT_BITS:0] n);
    logic [63:0] u;
    logic [63:0] c;
    logic [63:0] w;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] t;
    logic [63:0] p;
    u = 64'(n) << 40;
    c = '0;
    for (int b = 20; b >= 0; b--) begin
      t = c | (64'd1 << b);
      if (t * t * t <= u) c = t;
    end
    w = c << 42;
    s = '0;
    for (int b = 31; b >= 0; b--) begin
      t = s | (64'd1 << b);
      if (t * t <= w) s = t;
    end
    d = '0;
    for (int b = 31; b >= 0; b--) begin
      t = d | (64'd1 << b);
      if (t * t <= s) d = t;
    end
    p = (c * d + (64'd1 << 16)) >> 17;
    return WORD_W'(p);
  endfunction

endpackage

// ===== design/xrgc_matrix.sv =====
module xrgc_matrix #(
  parameter int IN_WIDTH = xrgc_pkg::DEF_IN_WIDTH,
  localparam int LIN_W = xrgc_pkg::lin_width(IN_WIDTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [xrgc_pkg::SEL_W-1:0]        sel_i,
  input  logic [IN_WIDTH-1:0]               x_i,
  input  logic [IN_WIDTH-1:0]               y_i,
  input  logic [IN_WIDTH-1:0]               z_i,
  output logic                              valid_o,
  output logic signed [LIN_W-1:0]           lin_o [xrgc_pkg::N_CHAN]
);

  localparam int PROD_W = xrgc_pkg::COEF_W + IN_WIDTH + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (xrgc_pkg::FRAC_BITS - 1);

  logic [IN_WIDTH-1:0]      comp [3];
  logic signed [PROD_W-1:0] prod_d [xrgc_pkg::N_CHAN][3];
  logic signed [PROD_W-1:0] prod_q [xrgc_pkg::N_CHAN][3];
  logic signed [SUM_W-1:0]  sum_d  [xrgc_pkg::N_CHAN];
  logic signed [LIN_W-1:0]  lin_d  [xrgc_pkg::N_CHAN];
  logic signed [LIN_W-1:0]  lin_q  [xrgc_pkg::N_CHAN];
  logic [1:0]               vld_q;

  assign comp[0] = x_i;
  assign comp[1] = y_i;
  assign comp[2] = z_i;

  // Stage 1: nine coefficient products
  always_comb begin
    for (int k = 0; k < xrgc_pkg::N_CHAN; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[k][j] = PROD_W'(xrgc_pkg::COEF[sel_i][3*k+j]) *
                       PROD_W'($signed({1'b0, comp[j]}));
      end
    end
  end

  // Stage 2: sum each row and round half up to Q.14
  always_comb begin
    for (int k = 0; k < xrgc_pkg::N_CHAN; k++) begin
      sum_d[k] = SUM_W'(prod_q[k][0]) + SUM_W'(prod_q[k][1]) + SUM_W'(prod_q[k][2]) + ROUND;
      lin_d[k] = LIN_W'(sum_d[k] >>> xrgc_pkg::FRAC_BITS);
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  // Hold the payload of each stage
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    lin_q  <= lin_d;
  end

  assign valid_o = vld_q[1];
  assign lin_o   = lin_q;

endmodule

// ===== design/xrgc_compand.sv =====
module xrgc_compand #(
  parameter int IN_WIDTH      = xrgc_pkg::DEF_IN_WIDTH,
  parameter int OUT_WIDTH     = xrgc_pkg::DEF_OUT_WIDTH,
  parameter int LUT_ADDR_BITS = xrgc_pkg::DEF_LUT_ADDR_BITS,
  localparam int LIN_W = xrgc_pkg::lin_width(IN_WIDTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [LIN_W-1:0]     lin_i,
  output logic signed [OUT_WIDTH-1:0] result_o,
  output xrgc_pkg::ch_stat_t          stat_o
);

  localparam int A         = LUT_ADDR_BITS;
  localparam int LB        = xrgc_pkg::LIMIT_BITS;
  localparam int WW        = xrgc_pkg::WORD_W;
  localparam int RW        = xrgc_pkg::RES_W;
  localparam int HALF      = 2 ** (A - 1);
  localparam int ROM_DEPTH = 2 ** A + (LB - A) * HALF + 1;
  localparam int K_W       = $clog2(ROM_DEPTH);
  localparam int SH_W      = $clog2(LB - A + 1);
  localparam int F_W       = LB - A;
  localparam int DP_W      = WW + F_W;
  localparam int GP_W      = xrgc_pkg::GAMMA_GAIN_W + WW;
  localparam int LPROD_W   = xrgc_pkg::MAG_W + xrgc_pkg::LIN_GAIN_W;
  localparam int LRES_W    = LPROD_W + 1 - xrgc_pkg::LIN_SHIFT;
  localparam int CMP_W     = (LIN_W > xrgc_pkg::MAG_W) ? LIN_W : xrgc_pkg::MAG_W;
  localparam int NST       = xrgc_pkg::COMPAND_STAGES;

  localparam logic [CMP_W-1:0]        MAG_CAP = CMP_W'(1) << (xrgc_pkg::MAG_W - 1);
  localparam logic signed [LIN_W-1:0] THRESH  = LIN_W'(xrgc_pkg::LIN_THRESHOLD);
  localparam logic signed [LIN_W-1:0] LIMIT   = LIN_W'((2 ** LB) - 1);
  localparam logic signed [RW-1:0]    SAT_HI  = (RW'(1) << (OUT_WIDTH - 1)) - RW'(1);
  localparam logic signed [RW-1:0]    SAT_LO  = ~SAT_HI;

  function automatic logic [4:0] msb_pos(input logic [LB-1:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < LB; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // Power table: segment 0 holds every node below 2^A, segment s holds nodes
  // idx << s for the upper half of idx, and the last word is the node 2^LB.
  // The right-hand node of any interval is always the next word.
  logic [WW-1:0] rom [ROM_DEPTH];

  for (genvar g = 0; g < 2 ** A; g++) begin : g_seg0
    localparam logic [WW-1:0] WORD = xrgc_pkg::pow_word((LB + 1)'(g));
    assign rom[g] = WORD;
  end
  for (genvar s = 1; s <= LB - A; s++) begin : g_seg
    for (genvar j = 0; j < HALF; j++) begin : g_node
      localparam logic [WW-1:0] WORD = xrgc_pkg::pow_word((LB + 1)'((HALF + j) << s));
      assign rom[2 ** A + (s - 1) * HALF + j] = WORD;
    end
  end
  localparam logic [WW-1:0] LAST_WORD = xrgc_pkg::pow_word((LB + 1)'(1) << LB);
  assign rom[ROM_DEPTH-1] = LAST_WORD;

  // Stage 1 signals
  logic                            gam_d;
  logic                            neg_d;
  logic                            clamp_d;
  logic [LIN_W-1:0]                magu;
  logic [CMP_W-1:0]                mag_ext;
  logic [xrgc_pkg::MAG_W-1:0]      mag_d;
  logic [LB-1:0]                   lv;
  logic [4:0]                      msb;
  logic [SH_W-1:0]                 sh_d;
  logic [A-1:0]                    idx;
  logic [F_W-1:0]                  f_d;
  logic [K_W-1:0]                  k_d;

  logic                            c1_gam_q, c1_neg_q, c1_clamp_q;
  logic [xrgc_pkg::MAG_W-1:0]      c1_mag_q;
  logic [SH_W-1:0]                 c1_sh_q;
  logic [F_W-1:0]                  c1_f_q;
  logic [K_W-1:0]                  c1_k_q;

  logic                            c2_gam_q, c2_neg_q, c2_clamp_q;
  logic [SH_W-1:0]                 c2_sh_q;
  logic [F_W-1:0]                  c2_f_q;
  logic [WW-1:0]                   c2_wa_q, c2_wb_q;
  logic [LPROD_W-1:0]              c2_lprod_q;

  logic [LPROD_W:0]                lsum;
  logic [LRES_W-1:0]               lmag;
  logic signed [RW-1:0]            lres_d;
  logic                            c3_gam_q, c3_clamp_q;
  logic [SH_W-1:0]                 c3_sh_q;
  logic [WW-1:0]                   c3_wa_q;
  logic [DP_W-1:0]                 c3_dprod_q;
  logic signed [RW-1:0]            c3_lres_q;

  logic [DP_W:0]                   dsum;
  logic [WW-1:0]                   v_d;
  logic                            c4_gam_q, c4_clamp_q;
  logic [WW-1:0]                   c4_v_q;
  logic signed [RW-1:0]            c4_lres_q;

  logic                            c5_gam_q, c5_clamp_q;
  logic [GP_W-1:0]                 c5_gprod_q;
  logic signed [RW-1:0]            c5_lres_q;

  logic [GP_W:0]                   gsum;
  logic signed [RW-1:0]            gres;
  logic signed [RW-1:0]            res;
  logic signed [OUT_WIDTH-1:0]     out_d;
  logic                            clip_d;
  logic signed [OUT_WIDTH-1:0]     out_q;
  logic                            clip_q;

  logic [NST-1:0]                  vld_q;

  // Stage 1: pick the branch, cap the magnitude, clamp to the table domain, find the segment
  always_comb begin
    gam_d   = lin_i > THRESH;
    neg_d   = lin_i[LIN_W-1];
    magu    = neg_d ? LIN_W'(-lin_i) : LIN_W'(lin_i);
    mag_ext = CMP_W'(magu);
    mag_d   = (mag_ext > MAG_CAP) ? xrgc_pkg::MAG_W'(MAG_CAP) : xrgc_pkg::MAG_W'(mag_ext);
    clamp_d = gam_d && (lin_i > LIMIT);
    lv      = clamp_d ? '1 : LB'(lin_i);
    msb     = msb_pos(lv);
    if (|lv[LB-1:A]) begin
      sh_d = SH_W'(msb - 5'(A - 1));
    end else begin
      sh_d = '0;
    end
    idx = A'(lv >> sh_d);
    f_d = F_W'(lv & ((LB'(1) << sh_d) - LB'(1)));
    k_d = gam_d ? (K_W'(idx) + (K_W'(sh_d) << (A - 1))) : '0;
  end

  // Stage 3: linear branch rounding and sign
  always_comb begin
    lsum   = (LPROD_W + 1)'(c2_lprod_q) + (LPROD_W + 1)'(1 << (xrgc_pkg::LIN_SHIFT - 1));
    lmag   = LRES_W'(lsum >> xrgc_pkg::LIN_SHIFT);
    lres_d = c2_neg_q ? -RW'(lmag) : RW'(lmag);
  end

  // Stage 4: finish the interpolation with rounding
  always_comb begin
    dsum = (DP_W + 1)'(c3_dprod_q) + (((DP_W + 1)'(1) << c3_sh_q) >> 1);
    v_d  = c3_wa_q + WW'(dsum >> c3_sh_q);
  end

  // Stage 6: scale and offset, merge the branches, saturate
  always_comb begin
    gsum = (GP_W + 1)'(c5_gprod_q) + (GP_W + 1)'(1 << (xrgc_pkg::GAMMA_SHIFT - 1));
    gres = RW'(gsum >> xrgc_pkg::GAMMA_SHIFT) - RW'(xrgc_pkg::GAMMA_OFFSET);
    res  = c5_gam_q ? gres : c5_lres_q;
    clip_d = c5_clamp_q;
    if (res > SAT_HI) begin
      out_d  = OUT_WIDTH'(SAT_HI);
      clip_d = 1'b1;
    end else if (res < SAT_LO) begin
      out_d  = OUT_WIDTH'(SAT_LO);
      clip_d = 1'b1;
    end else begin
      out_d  = OUT_WIDTH'(res);
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  // Hold the payload of each stage
  always_ff @(posedge clk_i) begin
    c1_gam_q   <= gam_d;
    c1_neg_q   <= neg_d;
    c1_clamp_q <= clamp_d;
    c1_mag_q   <= mag_d;
    c1_sh_q    <= sh_d;
    c1_f_q     <= f_d;
    c1_k_q     <= k_d;

    c2_gam_q   <= c1_gam_q;
    c2_neg_q   <= c1_neg_q;
    c2_clamp_q <= c1_clamp_q;
    c2_sh_q    <= c1_sh_q;
    c2_f_q     <= c1_f_q;
    c2_wa_q    <= rom[c1_k_q];
    c2_wb_q    <= rom[c1_k_q + K_W'(1)];
    c2_lprod_q <= LPROD_W'(c1_mag_q) * LPROD_W'(xrgc_pkg::LIN_GAIN);

    c3_gam_q   <= c2_gam_q;
    c3_clamp_q <= c2_clamp_q;
    c3_sh_q    <= c2_sh_q;
    c3_wa_q    <= c2_wa_q;
    c3_dprod_q <= DP_W'(c2_wb_q - c2_wa_q) * DP_W'(c2_f_q);
    c3_lres_q  <= lres_d;

    c4_gam_q   <= c3_gam_q;
    c4_clamp_q <= c3_clamp_q;
    c4_v_q     <= v_d;
    c4_lres_q  <= c3_lres_q;

    c5_gam_q   <= c4_gam_q;
    c5_clamp_q <= c4_clamp_q;
    c5_gprod_q <= GP_W'(c4_v_q) * GP_W'(xrgc_pkg::GAMMA_GAIN);
    c5_lres_q  <= c4_lres_q;

    out_q  <= out_d;
    clip_q <= clip_d;
  end

  assign result_o     = out_q;
  assign stat_o.valid = vld_q[NST-1];
  assign stat_o.clip  = clip_q;

endmodule

// ===== design/xyz_to_rgb_gamma_convert.sv =====
// Channel    Direction  Handshake                       Payload
// pixel in   input      start, busy                     x_in_i, y_in_i, z_in_i
// pixel out  output     out_valid_o (one-cycle strobe)  red_out_o, green_out_o,
//                                                       blue_out_o, clipped_o
// config     input      cfg_valid_i, cfg_ready_o        cfg_data_i (matrix select)
//
// One pixel per clock. Each transaction's result passes through two matrix stages
// (products, row sum) and six companding stages (segment search, power table read,
// slope product, interpolation, gain, saturate) on its way to the outputs.
// Reset clears the valid bits and selects the precise D65 matrix.
// The receiver cannot stall, so busy stays low and no transaction is ever held.
module xyz_to_rgb_gamma_convert #(
  parameter int IN_WIDTH            = xrgc_pkg::DEF_IN_WIDTH,
  parameter int OUT_WIDTH           = xrgc_pkg::DEF_OUT_WIDTH,
  parameter int GAMMA_LUT_ADDR_BITS = xrgc_pkg::DEF_LUT_ADDR_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [IN_WIDTH-1:0]         x_in_i,
  input  logic [IN_WIDTH-1:0]         y_in_i,
  input  logic [IN_WIDTH-1:0]         z_in_i,
  output logic                        out_valid_o,
  output logic signed [OUT_WIDTH-1:0] red_out_o,
  output logic signed [OUT_WIDTH-1:0] green_out_o,
  output logic signed [OUT_WIDTH-1:0] blue_out_o,
  output logic                        clipped_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [xrgc_pkg::SEL_W-1:0]  cfg_data_i
);

  localparam int LIN_W = xrgc_pkg::lin_width(IN_WIDTH);

  logic                          accept;
  logic [xrgc_pkg::SEL_W-1:0]    sel_q;
  logic                          mat_valid;
  logic signed [LIN_W-1:0]       lin [xrgc_pkg::N_CHAN];
  logic signed [OUT_WIDTH-1:0]   result [xrgc_pkg::N_CHAN];
  xrgc_pkg::ch_stat_t            chan_stat [xrgc_pkg::N_CHAN];

  // Take a transaction every cycle
  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Hold the matrix selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sel_q <= cfg_data_i;
    end
  end

  xrgc_matrix #(
    .IN_WIDTH (IN_WIDTH)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .sel_i   (sel_q),
    .x_i     (x_in_i),
    .y_i     (y_in_i),
    .z_i     (z_in_i),
    .valid_o (mat_valid),
    .lin_o   (lin)
  );

  for (genvar c = 0; c < xrgc_pkg::N_CHAN; c++) begin : g_chan
    xrgc_compand #(
      .IN_WIDTH      (IN_WIDTH),
      .OUT_WIDTH     (OUT_WIDTH),
      .LUT_ADDR_BITS (GAMMA_LUT_ADDR_BITS)
    ) u_compand (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (mat_valid),
      .lin_i    (lin[c]),
      .result_o (result[c]),
      .stat_o   (chan_stat[c])
    );
  end

  // Merge the three channels
  assign out_valid_o = chan_stat[0].valid && chan_stat[1].valid && chan_stat[2].valid;
  assign red_out_o   = result[0];
  assign green_out_o = result[1];
  assign blue_out_o  = result[2];
  assign clipped_o   = chan_stat[0].clip || chan_stat[1].clip || chan_stat[2].clip;

  // Every taken transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(xrgc_pkg::LATENCY) out_valid_o)
    else $error("transaction lost in the pipeline");

  // No result without a transaction taken the latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, xrgc_pkg::LATENCY))
    else $error("result without a matching transaction");

  // The three channel pipelines stay in step
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chan_stat[0].valid == chan_stat[1].valid) && (chan_stat[1].valid == chan_stat[2].valid))
    else $error("channel valid bits disagree");

endmodule
